// ===== rtl/core/heat_stencil_ftcs_2d_defines.svh =====
// Assertion macros shared by the heat stencil checkers
`ifndef HEAT_STENCIL_FTCS_2D_DEFINES_SVH
`define HEAT_STENCIL_FTCS_2D_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define HSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define HSF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle check after reset is seen
`define HSF_ASSERT_RST(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hsf_pkg.sv =====
// Shared constants and types for the FTCS heat stencil
package hsf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MIN_SIZE    = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int CFG_SIZE_W  = 11;
   localparam int CNT_W       = (COL_W + 1 > CFG_SIZE_W) ? COL_W + 1 : CFG_SIZE_W;
   localparam int OUT_COORD_W = 10;
   localparam int SAMPLE_W    = 18;
   localparam int COEF_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int FRAC_W      = 16;
   localparam int LAP_W       = SAMPLE_W + 2;
   localparam int PROD_W      = COEF_W + 1 + LAP_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int ROUND_HALF  = 32768;
   localparam int SAMPLE_MAX  = 131071;
   localparam int SAMPLE_MIN  = -131072;
   localparam int FIRST_INNER = 2;

   localparam int RST_GRID_WIDTH  = 64;
   localparam int RST_GRID_HEIGHT = 64;
   localparam int RST_COEF        = 13107;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH,
      CSR_GRID_HEIGHT,
      CSR_COEF_HORIZONTAL,
      CSR_COEF_VERTICAL
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // One grid column of the window: rows r-2, r-1 and r
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] up;
      logic signed [SAMPLE_W-1:0] mid;
      logic signed [SAMPLE_W-1:0] down;
   } column_type;

   // Per-item control travelling down the pipe
   typedef struct packed {
      logic             live;
      logic             int_f;
      logic             bnd_f;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } meta_type;

endpackage

// ===== rtl/core/hsf_row_ram.sv =====
// Single row store: one write port, one registered read port
module hsf_row_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [hsf_pkg::COL_W-1:0]      wr_addr,
   input  hsf_pkg::sample_type            wr_data,
   input  logic                           rd_en,
   input  logic [hsf_pkg::COL_W-1:0]      rd_addr,
   output hsf_pkg::sample_type            rd_data
);

   hsf_pkg::sample_type mem_ff [hsf_pkg::MAX_WIDTH];
   hsf_pkg::sample_type rd_data_ff;

   // read returns the old word when the same address is written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hsf_col_cell.sv =====
// One column cell of the 3x3 window chain
module hsf_col_cell (
   input  logic                clock,
   input  logic                shift,
   input  hsf_pkg::column_type column_in,
   output hsf_pkg::column_type column_out
);

   hsf_pkg::column_type column_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;

endmodule

// ===== rtl/core/hsf_stencil_pipe.sv =====
// Three-stage stencil arithmetic: Laplacians, products, round and saturate
module hsf_stencil_pipe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  hsf_pkg::column_type               win_left,
   input  hsf_pkg::column_type               win_mid,
   input  hsf_pkg::column_type               win_right,
   input  logic [hsf_pkg::COEF_W-1:0]        coef_x,
   input  logic [hsf_pkg::COEF_W-1:0]        coef_y,
   input  hsf_pkg::meta_type                 meta_in,
   output hsf_pkg::meta_type                 meta_out,
   output hsf_pkg::sample_type               value_out
);

   localparam int LW = hsf_pkg::LAP_W;
   localparam int PW = hsf_pkg::PROD_W;
   localparam int SW = hsf_pkg::SUM_W;

   hsf_pkg::sample_type     l_s, u_s, r_s, d_s, up_s;
   logic signed [LW-1:0]    lap_x_in, lap_y_in;
   logic signed [LW-1:0]    lap_x_ff, lap_y_ff;
   hsf_pkg::sample_type     u_a_ff, u_b_ff;
   logic signed [PW-1:0]    prod_x_in, prod_y_in;
   logic signed [PW-1:0]    prod_x_ff, prod_y_ff;
   logic signed [SW-1:0]    sum_s, quot_s;
   hsf_pkg::sample_type     value_in, value_ff;
   hsf_pkg::meta_type       meta_a_ff, meta_b_ff, meta_c_ff;

   always_comb begin
      l_s  = win_left.mid;
      u_s  = win_mid.mid;
      r_s  = win_right.mid;
      d_s  = win_mid.down;
      up_s = win_mid.up;
      lap_x_in = LW'(l_s) - (LW'(u_s) <<< 1) + LW'(r_s);
      lap_y_in = LW'(d_s) - (LW'(u_s) <<< 1) + LW'(up_s);
   end

   always_comb begin
      prod_x_in = $signed({1'b0, coef_x}) * lap_x_ff;
      prod_y_in = $signed({1'b0, coef_y}) * lap_y_ff;
   end

   // round half up: add half an LSB, then floor via arithmetic shift
   always_comb begin
      sum_s  = (SW'(u_b_ff) <<< hsf_pkg::FRAC_W) + SW'(prod_x_ff) + SW'(prod_y_ff)
             + SW'(hsf_pkg::ROUND_HALF);
      quot_s = sum_s >>> hsf_pkg::FRAC_W;
      if (quot_s > SW'(hsf_pkg::SAMPLE_MAX)) begin
         value_in = hsf_pkg::SAMPLE_W'(hsf_pkg::SAMPLE_MAX);
      end else if (quot_s < SW'(hsf_pkg::SAMPLE_MIN)) begin
         value_in = hsf_pkg::SAMPLE_W'(hsf_pkg::SAMPLE_MIN);
      end else begin
         value_in = quot_s[hsf_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lap_x_ff  <= lap_x_in;
         lap_y_ff  <= lap_y_in;
         u_a_ff    <= u_s;
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         u_b_ff    <= u_a_ff;
         value_ff  <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_a_ff <= '0;
         meta_b_ff <= '0;
         meta_c_ff <= '0;
      end else if (advance) begin
         meta_a_ff <= meta_in;
         meta_b_ff <= meta_a_ff;
         meta_c_ff <= meta_b_ff;
      end
   end

   assign meta_out  = meta_c_ff;
   assign value_out = value_ff;

endmodule

// ===== rtl/core/heat_stencil_ftcs_2d.sv =====
// Top level of the streaming FTCS 2D heat stencil (one time step per frame)
// Input: one signed Q2.16 sample per word on req_*, raster order, row 0 first.
// Output: one result word per cycle on rsp_* carrying column, row, new value
//   and last_of_run while rsp_stall is low; a sample causes 0, 1 or 2 results.
// An interior cell (c,r) is produced when sample (c+1,r+1) is accepted;
//   boundary cells are produced as zero with their own sample, after the
//   interior result of the same sample.
// Path of a result from the edge that accepted its causing sample: row-store
//   read, window shift, Laplacian, product and round/saturate stages, pending
//   stage, output register (the rsp registers).
// Throughput: one sample per cycle when rsp_stall is low; two-result samples
//   hold the input for their second word, as the port moves one word per cycle.
// When rsp_stall is high with a word waiting, the pipe keeps moving until a
//   result reaches the pending stage; then the whole pipe freezes and
//   req_stall rises in the same cycle.
// Reset: counters clear, csr registers take 64, 64, 13107, 13107, req_stall
//   is high while reset is held. The row stores are not cleared; a frame
//   writes them before reading. Change csr values only between frames.
module heat_stencil_ftcs_2d (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [hsf_pkg::SAMPLE_W-1:0]    req_sample_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [hsf_pkg::OUT_COORD_W-1:0]        rsp_out_column,
   output logic [hsf_pkg::OUT_COORD_W-1:0]        rsp_out_row,
   output logic signed [hsf_pkg::SAMPLE_W-1:0]    rsp_new_value,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_write_enable,
   input  logic [hsf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [hsf_pkg::CSR_DATA_W-1:0]         csr_write_data
);

   localparam int CW = hsf_pkg::CNT_W;
   localparam int OW = hsf_pkg::OUT_COORD_W;

   // configuration
   logic [hsf_pkg::CFG_SIZE_W-1:0] grid_width_ff, grid_height_ff;
   logic [hsf_pkg::COEF_W-1:0]     coef_h_ff, coef_v_ff;

   // raster position
   logic [hsf_pkg::COL_W-1:0] col_ff, col_in;
   logic [hsf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0] w_eff, h_eff, g_w, g_h;
   logic [CW-1:0] col_ext, row_ext, row_tmp, c_cur, r_cur, c_next, r_next;
   logic          int_f, bnd_f;

   logic accept, advance;

   // stage 1: row-store read data and the sample
   hsf_pkg::meta_type   s1_meta_ff, s1_meta_in;
   hsf_pkg::sample_type s1_sample_ff;
   hsf_pkg::sample_type above_rd, centre_rd;
   hsf_pkg::column_type col_new, col_c0, col_c1, col_c2;
   logic                shift;

   // stage 2 control (window holds the data)
   hsf_pkg::meta_type m2_meta_ff;

   hsf_pkg::meta_type   calc_meta;
   hsf_pkg::sample_type calc_value;

   // pending stage: up to two results left to emit
   hsf_pkg::meta_type   p_meta_ff, p_meta_in;
   hsf_pkg::sample_type p_value_ff;
   logic                pend_int_in, pend_bnd_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]       rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   hsf_pkg::sample_type rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                take;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= hsf_pkg::CFG_SIZE_W'(hsf_pkg::RST_GRID_WIDTH);
         grid_height_ff <= hsf_pkg::CFG_SIZE_W'(hsf_pkg::RST_GRID_HEIGHT);
         coef_h_ff      <= hsf_pkg::COEF_W'(hsf_pkg::RST_COEF);
         coef_v_ff      <= hsf_pkg::COEF_W'(hsf_pkg::RST_COEF);
      end else if (csr_write_enable) begin
         case (hsf_pkg::csr_index_type'(csr_index))
            hsf_pkg::CSR_GRID_WIDTH: begin
               grid_width_ff <= csr_write_data[hsf_pkg::CFG_SIZE_W-1:0];
            end
            hsf_pkg::CSR_GRID_HEIGHT: begin
               grid_height_ff <= csr_write_data[hsf_pkg::CFG_SIZE_W-1:0];
            end
            hsf_pkg::CSR_COEF_HORIZONTAL: begin
               coef_h_ff <= csr_write_data[hsf_pkg::COEF_W-1:0];
            end
            hsf_pkg::CSR_COEF_VERTICAL: begin
               coef_v_ff <= csr_write_data[hsf_pkg::COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clamp sizes to the supported range
   always_comb begin
      g_w = CW'(grid_width_ff);
      g_h = CW'(grid_height_ff);
      if (g_w < CW'(hsf_pkg::MIN_SIZE)) begin
         w_eff = CW'(hsf_pkg::MIN_SIZE);
      end else if (g_w > CW'(hsf_pkg::MAX_WIDTH)) begin
         w_eff = CW'(hsf_pkg::MAX_WIDTH);
      end else begin
         w_eff = g_w;
      end
      if (g_h < CW'(hsf_pkg::MIN_SIZE)) begin
         h_eff = CW'(hsf_pkg::MIN_SIZE);
      end else if (g_h > CW'(hsf_pkg::MAX_HEIGHT)) begin
         h_eff = CW'(hsf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = g_h;
      end
   end

   // position of the arriving sample and of the one after it
   always_comb begin
      col_ext = CW'(col_ff);
      row_ext = CW'(row_ff);
      if (col_ext >= w_eff) begin
         c_cur   = '0;
         row_tmp = row_ext + CW'(1);
      end else begin
         c_cur   = col_ext;
         row_tmp = row_ext;
      end
      r_cur  = (row_tmp >= h_eff) ? '0 : row_tmp;
      c_next = c_cur + CW'(1);
      r_next = r_cur + CW'(1);
      if (c_next >= w_eff) begin
         col_in = '0;
         row_in = (r_next >= h_eff) ? '0 : r_next[hsf_pkg::ROW_W-1:0];
      end else begin
         col_in = c_next[hsf_pkg::COL_W-1:0];
         row_in = r_cur[hsf_pkg::ROW_W-1:0];
      end
      int_f = (r_cur >= CW'(hsf_pkg::FIRST_INNER)) && (c_cur >= CW'(hsf_pkg::FIRST_INNER));
      bnd_f = (r_cur == '0) || (r_cur == h_eff - CW'(1))
           || (c_cur == '0) || (c_cur == w_eff - CW'(1));
   end

   assign req_stall = reset || !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      s1_meta_in       = '0;
      s1_meta_in.live  = accept;
      s1_meta_in.int_f = accept && int_f;
      s1_meta_in.bnd_f = accept && bnd_f;
      s1_meta_in.col   = c_cur[hsf_pkg::COL_W-1:0];
      s1_meta_in.row   = r_cur[hsf_pkg::ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_meta_ff <= '0;
         m2_meta_ff <= '0;
      end else if (advance) begin
         s1_meta_ff <= s1_meta_in;
         m2_meta_ff <= s1_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample_value;
      end
   end

   // row r-1: written with each sample, read before the write
   hsf_row_ram u_newer_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (c_cur[hsf_pkg::COL_W-1:0]),
      .wr_data (req_sample_value),
      .rd_en   (accept),
      .rd_addr (c_cur[hsf_pkg::COL_W-1:0]),
      .rd_data (centre_rd)
   );

   // row r-2: takes what the newer store held, written when the window shifts
   hsf_row_ram u_older_ram (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (s1_meta_ff.col),
      .wr_data (centre_rd),
      .rd_en   (accept),
      .rd_addr (c_cur[hsf_pkg::COL_W-1:0]),
      .rd_data (above_rd)
   );

   assign shift        = s1_meta_ff.live && advance;
   assign col_new.up   = above_rd;
   assign col_new.mid  = centre_rd;
   assign col_new.down = s1_sample_ff;

   hsf_col_cell u_cell0 (
      .clock      (clock),
      .shift      (shift),
      .column_in  (col_new),
      .column_out (col_c0)
   );

   hsf_col_cell u_cell1 (
      .clock      (clock),
      .shift      (shift),
      .column_in  (col_c0),
      .column_out (col_c1)
   );

   hsf_col_cell u_cell2 (
      .clock      (clock),
      .shift      (shift),
      .column_in  (col_c1),
      .column_out (col_c2)
   );

   hsf_stencil_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .win_left  (col_c2),
      .win_mid   (col_c1),
      .win_right (col_c0),
      .coef_x    (coef_h_ff),
      .coef_y    (coef_v_ff),
      .meta_in   (m2_meta_ff),
      .meta_out  (calc_meta),
      .value_out (calc_value)
   );

   // emit interior result first, then the boundary zero
   always_comb begin
      take         = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && !take;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      pend_int_in  = p_meta_ff.int_f;
      pend_bnd_in  = p_meta_ff.bnd_f;
      if (take && p_meta_ff.int_f) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = OW'(p_meta_ff.col - hsf_pkg::COL_W'(1));
         rsp_row_in   = OW'(p_meta_ff.row - hsf_pkg::ROW_W'(1));
         rsp_value_in = p_value_ff;
         rsp_last_in  = !p_meta_ff.bnd_f;
         pend_int_in  = 1'b0;
      end else if (take && p_meta_ff.bnd_f) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = OW'(p_meta_ff.col);
         rsp_row_in   = OW'(p_meta_ff.row);
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         pend_bnd_in  = 1'b0;
      end
      advance = !(pend_int_in || pend_bnd_in);
      if (advance) begin
         p_meta_in = calc_meta;
      end else begin
         p_meta_in       = p_meta_ff;
         p_meta_in.int_f = pend_int_in;
         p_meta_in.bnd_f = pend_bnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_meta_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_meta_ff    <= p_meta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_value_ff <= calc_value;
      end
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_new_value   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== rtl/core/hsf_checker.sv =====
// Port-level checks for the heat stencil, bound to the top level
`include "heat_stencil_ftcs_2d_defines.svh"

module hsf_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [hsf_pkg::SAMPLE_W-1:0]    req_sample_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [hsf_pkg::OUT_COORD_W-1:0]        rsp_out_column,
   input  logic [hsf_pkg::OUT_COORD_W-1:0]        rsp_out_row,
   input  logic signed [hsf_pkg::SAMPLE_W-1:0]    rsp_new_value,
   input  logic                                   rsp_last_of_run,
   input  logic                                   csr_write_enable,
   input  logic [hsf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [hsf_pkg::CSR_DATA_W-1:0]         csr_write_data
);

   // a stalled word holds
   `HSF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_value) && $stable(rsp_out_column) && $stable(rsp_out_row) && $stable(rsp_last_of_run), "rsp word changed while stalled")

   // nothing leaves right after reset
   `HSF_ASSERT_RST(a_rsp_reset, clock, reset, !rsp_valid, "rsp_valid high after reset")

   // first row and first column are boundary cells, always zero
   `HSF_ASSERT_IMP(a_edge_zero, clock, reset, rsp_valid && ((rsp_out_row == '0) || (rsp_out_column == '0)), (rsp_new_value == '0) && rsp_last_of_run, "edge cell not a zero last word")

   // a word that is not last is an interior cell
   `HSF_ASSERT_IMP(a_inner_first, clock, reset, rsp_valid && !rsp_last_of_run, (rsp_out_row != '0) && (rsp_out_column != '0), "non-last word on the edge")

endmodule

bind heat_stencil_ftcs_2d hsf_checker u_hsf_checker (.*);

// ===== tb/sv/tb_heat_stencil_ftcs_2d.sv =====
// Self-checking testbench for the streaming FTCS heat stencil over frames of varied size
`timescale 1ns / 100ps

module tb_heat_stencil_ftcs_2d;
   import hsf_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_FRAMES = 10;

   typedef struct {
      logic [OUT_COORD_W-1:0] col;
      logic [OUT_COORD_W-1:0] row;
      sample_type             value;
      logic                   last;
   } stencil_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sample_type             req_sample_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [OUT_COORD_W-1:0] rsp_out_column;
   logic [OUT_COORD_W-1:0] rsp_out_row;
   sample_type             rsp_new_value;
   logic                   rsp_last_of_run;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Grid model: configuration, row stores, window and raster position
   logic [CFG_SIZE_W-1:0]  grid_width_cfg = 11'(RST_GRID_WIDTH);
   logic [CFG_SIZE_W-1:0]  grid_height_cfg = 11'(RST_GRID_HEIGHT);
   logic [COEF_W-1:0]      coef_horizontal_cfg = 16'(RST_COEF);
   logic [COEF_W-1:0]      coef_vertical_cfg = 16'(RST_COEF);
   sample_type             older_row [MAX_WIDTH];
   sample_type             newer_row [MAX_WIDTH];
   sample_type             win_up = '0;
   sample_type             win_mid = '0;
   sample_type             win_left = '0;
   int                     col_count = 0;
   int                     row_count = 0;

   sample_type             sample_queue[$];
   stencil_word_type       predicted_cells[$];
   bit                     req_taken = 1'b0;
   int                     req_idle_pct = 0;
   int                     rsp_stall_pct = 0;
   int                     error_count = 0;
   int                     cycle_count = 0;

   heat_stencil_ftcs_2d u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_column   (rsp_out_column),
      .rsp_out_row      (rsp_out_row),
      .rsp_new_value    (rsp_new_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic int clamp_size(logic [CFG_SIZE_W-1:0] raw, int top);
      if (raw < MIN_SIZE) return MIN_SIZE;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   // u + cx*lap_x + cy*lap_y in Q.32, rounded half up to Q2.16 and saturated
   function automatic sample_type ftcs_update(sample_type u, sample_type lft,
                                              sample_type rgt, sample_type dn,
                                              sample_type upv);
      longint lap_x, lap_y, acc, q;
      lap_x = longint'(lft) - 2 * longint'(u) + longint'(rgt);
      lap_y = longint'(dn) - 2 * longint'(u) + longint'(upv);
      acc = longint'(u) * 65536 + longint'(coef_horizontal_cfg) * lap_x
          + longint'(coef_vertical_cfg) * lap_y + ROUND_HALF;
      q = acc >>> FRAC_W;
      if (q > SAMPLE_MAX) q = SAMPLE_MAX;
      if (q < SAMPLE_MIN) q = SAMPLE_MIN;
      return sample_type'(q);
   endfunction

   // Advance the grid model by one sample and queue the cells it completes
   task automatic step_stencil(input sample_type sample);
      int               w, h, c, r;
      sample_type       above, centre;
      bit               interior_hit, border_hit;
      stencil_word_type word;
      w = clamp_size(grid_width_cfg, MAX_WIDTH);
      h = clamp_size(grid_height_cfg, MAX_HEIGHT);
      if (col_count >= w) begin
         col_count = 0;
         row_count++;
      end
      if (row_count >= h) row_count = 0;
      c = col_count;
      r = row_count;
      above = older_row[c];
      centre = newer_row[c];
      interior_hit = (r >= FIRST_INNER && c >= FIRST_INNER);
      border_hit = (r == 0 || r == h - 1 || c == 0 || c == w - 1);
      // interior cell one row and one column behind goes first
      if (interior_hit) begin
         word.col = OUT_COORD_W'(c - 1);
         word.row = OUT_COORD_W'(r - 1);
         word.value = ftcs_update(win_mid, win_left, centre, newer_row[c - 1], win_up);
         word.last = !border_hit;
         predicted_cells.push_back(word);
      end
      if (border_hit) begin
         word.col = OUT_COORD_W'(c);
         word.row = OUT_COORD_W'(r);
         word.value = '0;
         word.last = 1'b1;
         predicted_cells.push_back(word);
      end
      win_left = win_mid;
      win_mid = centre;
      win_up = above;
      older_row[c] = centre;
      newer_row[c] = sample;
      col_count = c + 1;
      if (col_count >= w) begin
         col_count = 0;
         row_count = r + 1;
         if (row_count >= h) row_count = 0;
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_GRID_WIDTH: grid_width_cfg = data[CFG_SIZE_W-1:0];
         CSR_GRID_HEIGHT: grid_height_cfg = data[CFG_SIZE_W-1:0];
         CSR_COEF_HORIZONTAL: coef_horizontal_cfg = data[COEF_W-1:0];
         CSR_COEF_VERTICAL: coef_vertical_cfg = data[COEF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_grid(input logic [CSR_DATA_W-1:0] w_raw, h_raw, cx, cy);
      write_csr(CSR_GRID_WIDTH, w_raw);
      write_csr(CSR_GRID_HEIGHT, h_raw);
      write_csr(CSR_COEF_HORIZONTAL, cx);
      write_csr(CSR_COEF_VERTICAL, cy);
   endtask

   // Hold until every sample is in and every cell is out, then let the pipe drain
   task automatic wait_for_idle();
      while (sample_queue.size() != 0 || req_valid || predicted_cells.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 5))
         0: return sample_type'(SAMPLE_MAX);
         1: return sample_type'(SAMPLE_MIN);
         2: return sample_type'(int'($urandom_range(0, 64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   // Driver: change inputs on the falling edge, advance only after a taken word
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         if (!req_valid || req_taken) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_sample_value <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on accepted samples, check accepted result words
   always @(posedge clock) begin
      stencil_word_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) step_stencil(req_sample_value);
         if (rsp_valid && !rsp_stall) begin
            if (predicted_cells.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: unexpected word col %0d row %0d value %0d last %0b",
                           $realtime, rsp_out_column, rsp_out_row, rsp_new_value,
                           rsp_last_of_run);
            end else begin
               want = predicted_cells.pop_front();
               if (rsp_out_column !== want.col || rsp_out_row !== want.row ||
                   rsp_new_value !== want.value || rsp_last_of_run !== want.last) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display({"%0t: expected col %0d row %0d value %0d last %0b, ",
                               "got col %0d row %0d value %0d last %0b"},
                              $realtime, want.col, want.row, want.value, want.last,
                              rsp_out_column, rsp_out_row, rsp_new_value, rsp_last_of_run);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int                    frame_idx, row_idx, col_idx, item_total;
      logic [CSR_DATA_W-1:0] w_raw, h_raw;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lone interior cell far below its neighbors, strongest coefficients: clips high.
      // Width carries junk above the register and is below range; height is zero.
      configure_grid(16'hF802, 16'h0000, 16'hFFFF, 16'hFFFF);
      for (row_idx = 0; row_idx < 3; row_idx++)
         for (col_idx = 0; col_idx < 3; col_idx++)
            sample_queue.push_back((row_idx == 1 && col_idx == 1) ?
                                   sample_type'(SAMPLE_MIN) : sample_type'(SAMPLE_MAX));
      wait_for_idle();

      // Checkerboard, vertical pull only: interior cells clip both ways
      configure_grid(16'd4, 16'd4, 16'h0000, 16'hFFFF);
      for (row_idx = 0; row_idx < 4; row_idx++)
         for (col_idx = 0; col_idx < 4; col_idx++)
            sample_queue.push_back(((row_idx + col_idx) % 2 == 0) ?
                                   sample_type'(SAMPLE_MAX) : sample_type'(SAMPLE_MIN));
      wait_for_idle();

      for (frame_idx = 0; frame_idx < RANDOM_FRAMES; frame_idx++) begin
         case (frame_idx % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin req_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         w_raw = CSR_DATA_W'($urandom_range(3, 12));
         h_raw = CSR_DATA_W'($urandom_range(3, 9));
         configure_grid(w_raw, h_raw, random_coef(), random_coef());
         item_total = clamp_size(w_raw[CFG_SIZE_W-1:0], MAX_WIDTH) *
                      clamp_size(h_raw[CFG_SIZE_W-1:0], MAX_HEIGHT);
         for (int i = 0; i < item_total; i++)
            sample_queue.push_back(random_sample());
         wait_for_idle();
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
